// ===== sv/console_text_ring_writer_unit_macros.svh =====
// Assertion macros shared by the console ring writer RTL.
`ifndef CONSOLE_TEXT_RING_WRITER_UNIT_MACROS_SVH
`define CONSOLE_TEXT_RING_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTRW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctrw: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctrw: next-cycle check failed");

`endif

// ===== sv/ctrw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the console ring writer.
`timescale 1ns / 1ps
`default_nettype none

package ctrw_pkg;

	// Field and register widths.
	localparam int CH_W       = 8;
	localparam int PTR_OUT_W  = 17;
	localparam int LEN_W      = 8;
	localparam int LW_W       = 9;
	localparam int BC_W       = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int PROD_W     = 17;

	// Ring size limits.
	localparam int MAX_CELLS_DEF = 131072;
	localparam int BC_MAX        = 262143;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_LINES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CELLS = 2'd2;

	// Register reset values and limits.
	localparam logic [LW_W-1:0] LW_RST  = 9'd80;
	localparam logic [LW_W-1:0] SL_RST  = 9'd25;
	localparam logic [BC_W-1:0] BC_RST  = 18'd4000;
	localparam logic [LW_W-1:0] LW_MAX  = 9'd256;
	localparam logic [LW_W-1:0] LW_ONE  = 9'd1;
	localparam logic [BC_W-1:0] BC_MIN  = 18'd2;

	// Character codes.
	localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CH_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [LEN_W-1:0] TAB_SPACES  = 8'd4;
	localparam logic [LEN_W-1:0] ONE_CELL    = 8'd1;

	// Character class after decode.
	typedef enum logic [1:0] {
		CLS_PRINT   = 2'd0,
		CLS_NEWLINE = 2'd1,
		CLS_BACK    = 2'd2,
		CLS_TAB     = 2'd3
	} chr_cls_t;

	// Operand pair fed to the remainder unit.
	typedef enum logic [2:0] {
		SRC_VIEW   = 3'd0,
		SRC_TAIL   = 3'd1,
		SRC_DIST   = 3'd2,
		SRC_ADV    = 3'd3,
		SRC_SCROLL = 3'd4
	} rem_src_t;

	typedef struct packed {
		logic     accept;
		logic     rem_start;
		rem_src_t rem_src;
		logic     ld_head;
		logic     ld_tail;
		logic     decode;
		logic     ld_nl;
		logic     ld_adv;
		logic     ld_scroll;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic     rem_done;
		logic     rem_zero;
		chr_cls_t cls;
		logic     scroll_hit;
	} stat_t;

endpackage

`default_nettype wire

// ===== sv/ctrw_rem.sv =====
// Serial remainder unit: one restoring step per cycle, with a short path for small quotients.
`timescale 1ns / 1ps
`default_nettype none
`include "console_text_ring_writer_unit_macros.svh"

module ctrw_rem #(
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [DW-1:0] rem
);
	localparam int CNTW = $clog2(DW);

	logic            chk_q;
	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   a_q;
	logic [DW-1:0]   b_q;
	logic [DW-1:0]   r_q;

	logic [DW:0]     trial;
	logic [DW:0]     b_x;
	logic            fits;
	logic [DW-1:0]   diff;
	logic            short_path;

	assign trial      = {r_q, a_q[DW-1]};
	assign b_x        = {1'b0, b_q};
	assign fits       = (trial >= b_x);
	assign diff       = a_q - b_q;
	assign short_path = (a_q < b_q) || (diff < b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				chk_q <= 1'b1;
			end else if (chk_q) begin
				chk_q <= 1'b0;
				if (short_path) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (chk_q) begin
			if (a_q < b_q) begin
				r_q <= a_q;
			end else if (diff < b_q) begin
				r_q <= diff;
			end else begin
				r_q   <= '0;
				cnt_q <= CNTW'(DW - 1);
			end
		end else if (busy_q) begin
			r_q   <= fits ? DW'(trial - b_x) : DW'(trial);
			a_q   <= {a_q[DW-2:0], 1'b0};
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	`CTRW_ASSERT_IMP(a_rem_start_idle, clk, arst_n, start, !chk_q && !busy_q)
	`CTRW_ASSERT_IMP(a_rem_done_after_work, clk, arst_n, done_q, $past(chk_q || busy_q))
	`CTRW_ASSERT_IMP(a_rem_below_divisor, clk, arst_n, done_q, r_q < b_q)

endmodule

`default_nettype wire

// ===== sv/ctrw_dp.sv =====
// Datapath of the console ring writer: registers, pointer arithmetic and result word.
`timescale 1ns / 1ps
`default_nettype none
`include "console_text_ring_writer_unit_macros.svh"

module ctrw_dp #(
	parameter int MAX_CELLS = ctrw_pkg::MAX_CELLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctrw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ctrw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [ctrw_pkg::CH_W-1:0]           ch,
	input  ctrw_pkg::cmd_t                      cmd,
	output ctrw_pkg::stat_t                     stat,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]      run_start,
	output logic [ctrw_pkg::LEN_W-1:0]          run_length,
	output logic [ctrw_pkg::CH_W-1:0]           run_char,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]      view_start,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]      write_end,
	output logic                                scrolled
);
	import ctrw_pkg::*;

	// Largest ring the block can see: the parameter or the register's reach.
	localparam int SIZE_CAP = (MAX_CELLS < BC_MAX) ? MAX_CELLS : BC_MAX;
	localparam int PW       = $clog2(SIZE_CAP);
	localparam int SW       = $clog2(SIZE_CAP + 1);
	localparam int DW       = ((PW > LW_W) ? PW : LW_W) + 1;
	localparam int CW       = (PW > PROD_W) ? PW : PROD_W;
	localparam int CXW      = CW + 1;

	// Configuration registers.
	logic [LW_W-1:0] lw_q;
	logic [LW_W-1:0] sl_q;
	logic [BC_W-1:0] bc_q;

	// Pointer state.
	logic [PW-1:0] vp_q;
	logic [PW-1:0] tp_q;

	// Per-character working registers.
	logic [CH_W-1:0]   ch_q;
	logic [LW_W-1:0]   w_q;
	logic [PROD_W-1:0] lo_q;
	logic [SW-1:0]     size_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [PW-1:0]     start_q;
	logic [LEN_W-1:0]  len_q;
	logic [CH_W-1:0]   fill_q;
	logic              scr_q;

	// Result word.
	logic [PTR_OUT_W-1:0] o_start_q;
	logic [LEN_W-1:0]     o_len_q;
	logic [CH_W-1:0]      o_char_q;
	logic [PTR_OUT_W-1:0] o_view_q;
	logic [PTR_OUT_W-1:0] o_end_q;
	logic                 o_scr_q;

	logic [LW_W-1:0]   w_c;
	logic [LW_W-1:0]   h_c;
	logic [SW-1:0]     size_c;
	logic [PROD_W-1:0] prod;
	logic [PW-1:0]     span;
	logic [PW-1:0]     tail_dec;
	logic [DW-1:0]     div_a;
	logic [DW-1:0]     div_b;
	logic [DW-1:0]     rem;
	logic              rem_done;
	logic              rem_zero;
	chr_cls_t          cls;
	logic [CXW-1:0]    d_x;
	logic [CXW-1:0]    lo_x;
	logic [CXW-1:0]    hi_x;
	logic              ptrs_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LW_RST;
			sl_q <= SL_RST;
			bc_q <= BC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   lw_q <= cfg_data[LW_W-1:0];
				CFG_SCREEN_LINES: sl_q <= cfg_data[LW_W-1:0];
				CFG_BUFFER_CELLS: bc_q <= cfg_data[BC_W-1:0];
				default:          ;
			endcase
		end
	end

	// Out-of-range settings are pulled into range.
	always_comb begin
		if (lw_q == '0) begin
			w_c = LW_ONE;
		end else if (lw_q > LW_MAX) begin
			w_c = LW_MAX;
		end else begin
			w_c = lw_q;
		end
		if (sl_q == '0) begin
			h_c = LW_ONE;
		end else if (sl_q > LW_MAX) begin
			h_c = LW_MAX;
		end else begin
			h_c = sl_q;
		end
		if (bc_q < BC_MIN) begin
			size_c = SW'(2);
		end else if (32'(bc_q) > SIZE_CAP) begin
			size_c = SW'(SIZE_CAP);
		end else begin
			size_c = SW'(bc_q);
		end
	end

	// Cells in all lines of the screen but the last: the scroll threshold.
	assign prod = PROD_W'(h_c - LW_ONE) * PROD_W'(w_c);

	assign span = (tail_q >= head_q) ? (tail_q - head_q)
		: PW'(DW'(tail_q) + DW'(size_q) - DW'(head_q));

	assign tail_dec = (tail_q == '0) ? PW'(size_q - SW'(1)) : (tail_q - PW'(1));

	always_comb begin
		case (ch_q)
			CH_NEWLINE:            cls = CLS_NEWLINE;
			CH_BACKSPACE, CH_RETURN: cls = CLS_BACK;
			CH_TAB:                cls = CLS_TAB;
			default:               cls = CLS_PRINT;
		endcase
	end

	always_comb begin
		case (cmd.rem_src)
			SRC_VIEW: begin
				div_a = DW'(vp_q);
				div_b = DW'(size_q);
			end
			SRC_TAIL: begin
				div_a = DW'(tp_q);
				div_b = DW'(size_q);
			end
			SRC_DIST: begin
				div_a = DW'(span);
				div_b = DW'(w_q);
			end
			SRC_ADV: begin
				div_a = DW'(tail_q) + DW'(len_q);
				div_b = DW'(size_q);
			end
			SRC_SCROLL: begin
				div_a = DW'(head_q) + DW'(w_q);
				div_b = DW'(size_q);
			end
			default: begin
				div_a = DW'(vp_q);
				div_b = DW'(size_q);
			end
		endcase
	end

	ctrw_rem #(
		.DW(DW)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.rem_start),
		.a     (div_a),
		.b     (div_b),
		.done  (rem_done),
		.rem   (rem)
	);

	assign rem_zero = (rem == '0);

	// The view scrolls when the text spans more than all lines but the last and at most the full screen.
	assign d_x  = CXW'(span);
	assign lo_x = CXW'(lo_q);
	assign hi_x = lo_x + CXW'(w_q);

	always_comb begin
		stat.rem_done   = rem_done;
		stat.rem_zero   = rem_zero;
		stat.cls        = cls;
		stat.scroll_hit = (d_x > lo_x) && (d_x <= hi_x);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q    <= ch;
			w_q     <= w_c;
			lo_q    <= prod;
			size_q  <= size_c;
			len_q   <= '0;
			fill_q  <= '0;
			start_q <= '0;
			scr_q   <= 1'b0;
		end
		if (cmd.ld_head) begin
			head_q <= PW'(rem);
		end
		if (cmd.ld_tail) begin
			tail_q <= PW'(rem);
		end
		if (cmd.decode) begin
			case (cls)
				CLS_BACK: tail_q <= tail_dec;
				CLS_TAB: begin
					len_q  <= TAB_SPACES;
					fill_q <= CH_SPACE;
				end
				CLS_PRINT: begin
					len_q  <= ONE_CELL;
					fill_q <= ch_q;
				end
				default: ;
			endcase
		end
		if (cmd.ld_nl && !rem_zero) begin
			len_q  <= LEN_W'(w_q - rem[LW_W-1:0]);
			fill_q <= CH_SPACE;
		end
		if (cmd.ld_adv) begin
			start_q <= tail_q;
			tail_q  <= PW'(rem);
		end
		if (cmd.ld_scroll) begin
			head_q <= PW'(rem);
			scr_q  <= 1'b1;
		end
		if (cmd.finish) begin
			o_start_q <= PTR_OUT_W'(start_q);
			o_len_q   <= len_q;
			o_char_q  <= fill_q;
			o_view_q  <= PTR_OUT_W'(head_q);
			o_end_q   <= PTR_OUT_W'(tail_q);
			o_scr_q   <= scr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
			tp_q <= '0;
		end else if (cmd.finish) begin
			vp_q <= head_q;
			tp_q <= tail_q;
		end
	end

	assign run_start  = o_start_q;
	assign run_length = o_len_q;
	assign run_char   = o_char_q;
	assign view_start = o_view_q;
	assign write_end  = o_end_q;
	assign scrolled   = o_scr_q;

	// Both stored pointers lie inside the ring.
	assign ptrs_ok = (DW'(vp_q) < DW'(size_q)) && (DW'(tp_q) < DW'(size_q));

	`CTRW_ASSERT_NEXT(a_dp_ptrs_in_ring, clk, arst_n, cmd.finish, ptrs_ok)

endmodule

`default_nettype wire

// ===== sv/ctrw_ctrl.sv =====
// Controller state machine of the console ring writer.
`timescale 1ns / 1ps
`default_nettype none
`include "console_text_ring_writer_unit_macros.svh"

module ctrw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output ctrw_pkg::cmd_t  cmd,
	input  ctrw_pkg::stat_t stat
);
	import ctrw_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_HEAD_GO   = 11'b00000000010,
		S_HEAD_WAIT = 11'b00000000100,
		S_TAIL_WAIT = 11'b00000001000,
		S_DECODE    = 11'b00000010000,
		S_NL_WAIT   = 11'b00000100000,
		S_ADV_GO    = 11'b00001000000,
		S_ADV_WAIT  = 11'b00010000000,
		S_SCR_CHK   = 11'b00100000000,
		S_SCR_WAIT  = 11'b01000000000,
		S_DONE      = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_HEAD_GO;
				end
			end
			S_HEAD_GO: begin
				cmd.rem_start = 1'b1;
				cmd.rem_src   = SRC_VIEW;
				state_d       = S_HEAD_WAIT;
			end
			S_HEAD_WAIT: begin
				if (stat.rem_done) begin
					cmd.ld_head   = 1'b1;
					cmd.rem_start = 1'b1;
					cmd.rem_src   = SRC_TAIL;
					state_d       = S_TAIL_WAIT;
				end
			end
			S_TAIL_WAIT: begin
				if (stat.rem_done) begin
					cmd.ld_tail = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				case (stat.cls)
					CLS_NEWLINE: begin
						cmd.rem_start = 1'b1;
						cmd.rem_src   = SRC_DIST;
						state_d       = S_NL_WAIT;
					end
					CLS_BACK: state_d = S_SCR_CHK;
					default:  state_d = S_ADV_GO;
				endcase
			end
			S_NL_WAIT: begin
				if (stat.rem_done) begin
					cmd.ld_nl = 1'b1;
					state_d   = stat.rem_zero ? S_SCR_CHK : S_ADV_GO;
				end
			end
			S_ADV_GO: begin
				cmd.rem_start = 1'b1;
				cmd.rem_src   = SRC_ADV;
				state_d       = S_ADV_WAIT;
			end
			S_ADV_WAIT: begin
				if (stat.rem_done) begin
					cmd.ld_adv = 1'b1;
					state_d    = S_SCR_CHK;
				end
			end
			S_SCR_CHK: begin
				if (stat.scroll_hit) begin
					cmd.rem_start = 1'b1;
					cmd.rem_src   = SRC_SCROLL;
					state_d       = S_SCR_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCR_WAIT: begin
				if (stat.rem_done) begin
					cmd.ld_scroll = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				// The result register is free when empty or being taken now.
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.finish | (out_valid_q & out_stall);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`CTRW_ASSERT_NEXT(a_ctrl_finish_shows, clk, arst_n, cmd.finish, out_valid_q)
	`CTRW_ASSERT_NEXT(a_ctrl_accept_starts, clk, arst_n, (state_q == S_IDLE) && in_valid, state_q == S_HEAD_GO)

endmodule

`default_nettype wire

// ===== sv/console_text_ring_writer_unit.sv =====
// Top level of the console ring writer: one character in, one buffer-write run out.
//
// Usage: the input channel carries one character byte per word (in_valid, in_stall, ch).
// For each accepted character the block returns exactly one result word on the output
// channel (out_valid, out_stall): the run of ring cells written (run_start, run_length,
// run_char) and the view start and write end pointers after the character, plus a flag
// that says whether the view scrolled by one line.
// The block works on one character at a time. It reduces the view and write pointers into
// the ring, decodes the byte, pads a newline to the end of its line, advances the write
// pointer past the run (a backspace or carriage return steps it back instead) and scrolls
// the view when needed. The pace is set by the shared serial remainder unit,
// which reduces pointers modulo the ring size and line offsets modulo the line width; a
// reduction that needs more than one subtraction runs one restoring step per dividend bit.
// The next character is accepted as soon as the previous result sits in the output
// register, so a stalled receiver delays only the finishing step of the next character.
// Reset clears both pointers and loads the default line width, screen height and ring size.
// The configuration port is always ready; writes are expected only while no character is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

module console_text_ring_writer_unit #(
	parameter int MAX_CELLS = ctrw_pkg::MAX_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ctrw_pkg::CH_W-1:0]       ch,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]  run_start,
	output logic [ctrw_pkg::LEN_W-1:0]      run_length,
	output logic [ctrw_pkg::CH_W-1:0]       run_char,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]  view_start,
	output logic [ctrw_pkg::PTR_OUT_W-1:0]  write_end,
	output logic                            scrolled,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ctrw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctrw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctrw_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	// Register writes are taken straight into the registers, so the port never pushes back.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// The controller sequences each character; the datapath holds the configuration, pointer and result registers.
	ctrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	ctrw_dp #(
		.MAX_CELLS(MAX_CELLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ch        (ch),
		.cmd       (cmd),
		.stat      (stat),
		.run_start (run_start),
		.run_length(run_length),
		.run_char  (run_char),
		.view_start(view_start),
		.write_end (write_end),
		.scrolled  (scrolled)
	);

endmodule

`default_nettype wire
